@@ rtl/mrk_pkg.sv @@
`default_nettype none
package mrk_pkg;

    localparam int LEVELS  = 32;
    localparam int LV_W    = $clog2(LEVELS + 1);
    localparam int ADDR_W  = $clog2(LEVELS);
    localparam int CNT_W   = LEVELS + 1;
    localparam int HASH_W  = 256;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 264;

    typedef logic [7:0][31:0]  state_t;
    typedef logic [15:0][31:0] block_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MUTABLE   = 2'd0,
        REG_FAST      = 2'd1,
        REG_BRANCH_EN = 2'd2,
        REG_BRANCH_POS = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_PAD    = 2'd1,
        PH_OUTER  = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LF_TEST,
        ST_LF_RD,
        ST_BR,
        ST_PAIR,
        ST_H_GO,
        ST_H_WAIT,
        ST_NEXT,
        ST_SW_START,
        ST_SW_FIND,
        ST_SW_LOAD,
        ST_SW_OUT,
        ST_SW_SELF,
        ST_SW_ADV,
        ST_SW_IN,
        ST_ROOT
    } st_t;

    localparam state_t STD_IV = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    localparam state_t FIXED_IV = '{
        32'haf5e2506, 32'hef98318f, 32'hdc24a3bc, 32'h0af2f450,
        32'h94f34b9d, 32'h08c8af1c, 32'h5a4bc81c, 32'h1e4e0f95};

    localparam logic [31:0] PAD_HEAD  = 32'h80000000;
    localparam logic [31:0] LEN_PAIR  = 32'h00000200;
    localparam logic [31:0] LEN_HASH  = 32'h00000100;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // byte 4j of the hash is the top byte of word j
    function automatic state_t hash_to_words(input logic [HASH_W-1:0] h);
        state_t w;
        for (int j = 0; j < 8; j++) begin
            w[j] = {h[32*j +: 8], h[32*j+8 +: 8], h[32*j+16 +: 8], h[32*j+24 +: 8]};
        end
        return w;
    endfunction

    function automatic logic [HASH_W-1:0] words_to_hash(input state_t w);
        logic [HASH_W-1:0] h;
        for (int j = 0; j < 8; j++) begin
            h[32*j +: 32] = {w[j][7:0], w[j][15:8], w[j][23:16], w[j][31:24]};
        end
        return h;
    endfunction

endpackage
`default_nettype wire

@@ rtl/streaming_merkle_root_and_branch_top.sv @@
// A leaf costs one pair hash per tree level it closes; a pair hash is one compression in
// fast mode and three in double mode (one round a cycle in the shared compression unit).
// The final sweep costs one pair hash per level it merges, plus one per self-pairing.
// Throughput: one transaction at a time, s_tready high only between transactions; a pending
// result that m_tready holds off stalls the sequencer until the output register frees.
// Reset: synchronous, active low; clears counters, match tracking and configuration to
// defaults. The subtree store is not cleared; an entry is read only after it is written.
`default_nettype none
module streaming_merkle_root_and_branch_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mrk_pkg::IN_TDATA_W-1:0]     s_tdata,  // leaf_w0, leaf_w1, leaf_w2, leaf_w3
    input  wire logic                               s_tuser,  // has_leaf
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mrk_pkg::OUT_TDATA_W-1:0]         m_tdata,  // hash_w0..hash_w3, mutated, pad
    output logic                                    m_tuser,  // kind
    output logic                                    m_tlast,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mrk_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [mrk_pkg::CFG_W-1:0]          cfg_wdata
);
    import mrk_pkg::*;

    localparam logic [CNT_W-1:0] LEAF_MAX = CNT_W'((CNT_W'(1) << LEVELS) - 1);

    st_t                 st_reg, st_next, ret_reg, ret_next;
    phase_t              ph_reg, ph_next;
    logic                mutable_reg, fast_reg, br_en_reg;
    logic [COUNT_W-1:0]  br_pos_reg;
    logic [COUNT_W-1:0]  cnt_leaf_reg, cnt_leaf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LV_W-1:0]     lv_reg, lv_next, ml_reg, ml_next;
    logic                ml_valid_reg, ml_valid_next;
    logic                mut_reg, mut_next, mh_reg, mh_next, sw_reg, sw_next, eol_reg, eol_next;
    logic [HASH_W-1:0]   h_reg, h_next, sib_reg, sib_next, hl_reg, hl_next;
    state_t              mid_reg, mid_next;

    logic                out_valid_reg;
    logic [HASH_W-1:0]   out_hash_reg;
    logic                out_kind_reg, out_mut_reg, out_last_reg;
    logic                emit, emit_kind, emit_mut;
    logic [HASH_W-1:0]   emit_hash;
    logic                out_free, br_need;

    logic                ram_we;
    logic [HASH_W-1:0]   ram_rd;
    logic                core_start, core_busy, core_done;
    state_t              core_iv, core_dig;
    block_t              core_blk;
    state_t              wl, wr;

    mrk_ram #(.WIDTH(HASH_W), .DEPTH(LEVELS)) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (lv_reg[ADDR_W-1:0]),
        .wr_data (h_reg),
        .rd_addr (lv_reg[ADDR_W-1:0]),
        .rd_data (ram_rd)
    );

    mrk_sha_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .iv      (core_iv),
        .blk     (core_blk),
        .busy    (core_busy),
        .done    (core_done),
        .digest  (core_dig)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign br_need  = br_en_reg && (mh_reg || (ml_valid_reg && ml_reg == lv_reg));
    assign wl       = hash_to_words(hl_reg);
    assign wr       = hash_to_words(h_reg);

    always_comb begin
        unique case (ph_reg)
            PH_FIRST: begin
                core_iv  = fast_reg ? FIXED_IV : STD_IV;
                core_blk = {wr, wl};
            end
            PH_PAD: begin
                core_iv  = mid_reg;
                core_blk = '0;
                core_blk[0]  = PAD_HEAD;
                core_blk[15] = LEN_PAIR;
            end
            PH_OUTER: begin
                core_iv  = STD_IV;
                core_blk = '0;
                core_blk[7:0] = mid_reg;
                core_blk[8]   = PAD_HEAD;
                core_blk[15]  = LEN_HASH;
            end
            default: begin
                core_iv  = STD_IV;
                core_blk = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            ph_reg       <= PH_FIRST;
            mutable_reg  <= 1'b1;
            fast_reg     <= 1'b0;
            br_en_reg    <= 1'b0;
            br_pos_reg   <= '1;
            cnt_leaf_reg <= '0;
            cnt_reg      <= '0;
            lv_reg       <= '0;
            ml_reg       <= '0;
            ml_valid_reg <= 1'b0;
            mut_reg      <= 1'b0;
            mh_reg       <= 1'b0;
            sw_reg       <= 1'b0;
            eol_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            ret_reg      <= ret_next;
            ph_reg       <= ph_next;
            cnt_leaf_reg <= cnt_leaf_next;
            cnt_reg      <= cnt_next;
            lv_reg       <= lv_next;
            ml_reg       <= ml_next;
            ml_valid_reg <= ml_valid_next;
            mut_reg      <= mut_next;
            mh_reg       <= mh_next;
            sw_reg       <= sw_next;
            eol_reg      <= eol_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_MUTABLE:    mutable_reg <= cfg_wdata[0];
                    REG_FAST:       fast_reg    <= cfg_wdata[0];
                    REG_BRANCH_EN:  br_en_reg   <= cfg_wdata[0];
                    REG_BRANCH_POS: br_pos_reg  <= cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg   <= h_next;
        sib_reg <= sib_next;
        hl_reg  <= hl_next;
        mid_reg <= mid_next;
        if (emit) begin
            out_hash_reg <= emit_hash;
            out_kind_reg <= emit_kind;
            out_mut_reg  <= emit_mut;
            out_last_reg <= emit_kind;
        end
    end

    always_comb begin
        st_next       = st_reg;
        ret_next      = ret_reg;
        ph_next       = ph_reg;
        cnt_leaf_next = cnt_leaf_reg;
        cnt_next      = cnt_reg;
        lv_next       = lv_reg;
        ml_next       = ml_reg;
        ml_valid_next = ml_valid_reg;
        mut_next      = mut_reg;
        mh_next       = mh_reg;
        sw_next       = sw_reg;
        eol_next      = eol_reg;
        h_next        = h_reg;
        sib_next      = sib_reg;
        hl_next       = hl_reg;
        mid_next      = mid_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        core_start    = 1'b0;
        emit          = 1'b0;
        emit_kind     = 1'b0;
        emit_mut      = 1'b0;
        emit_hash     = h_reg;

        unique case (st_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    h_next   = s_tdata[HASH_W-1:0];
                    eol_next = s_tlast;
                    sw_next  = 1'b0;
                    if (s_tuser && CNT_W'(cnt_leaf_reg) != LEAF_MAX) begin
                        mh_next       = (cnt_leaf_reg == br_pos_reg);
                        cnt_leaf_next = cnt_leaf_reg + COUNT_W'(1);
                        cnt_next      = CNT_W'(cnt_leaf_reg) + CNT_W'(1);
                        lv_next       = '0;
                        st_next       = ST_LF_TEST;
                    end else if (s_tlast) begin
                        st_next = ST_SW_START;
                    end
                end
            end
            ST_LF_TEST: begin
                if (lv_reg < LV_W'(LEVELS - 1) && !cnt_reg[lv_reg]) begin
                    st_next = ST_LF_RD;
                end else begin
                    ram_we = 1'b1;
                    if (mh_reg) begin
                        ml_next       = lv_reg;
                        ml_valid_next = 1'b1;
                    end
                    st_next = eol_reg ? ST_SW_START : ST_IDLE;
                end
            end
            ST_LF_RD: begin
                sib_next = ram_rd;
                st_next  = ST_BR;
            end
            ST_BR: begin
                if (!br_need) begin
                    st_next = ST_PAIR;
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_hash = mh_reg ? sib_reg : h_reg;
                    mh_next   = 1'b1;
                    st_next   = ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (!sw_reg && sib_reg == h_reg) begin
                    mut_next = 1'b1;
                end
                hl_next  = sib_reg;
                ph_next  = PH_FIRST;
                ret_next = ST_NEXT;
                st_next  = ST_H_GO;
            end
            ST_H_GO: begin
                if (!core_busy) begin
                    core_start = 1'b1;
                    st_next    = ST_H_WAIT;
                end
            end
            ST_H_WAIT: begin
                if (core_done) begin
                    mid_next = core_dig;
                    if (fast_reg || ph_reg == PH_OUTER) begin
                        h_next  = words_to_hash(core_dig);
                        ph_next = PH_FIRST;
                        st_next = ret_reg;
                    end else begin
                        ph_next = (ph_reg == PH_FIRST) ? PH_PAD : PH_OUTER;
                        st_next = ST_H_GO;
                    end
                end
            end
            ST_NEXT: begin
                lv_next = lv_reg + LV_W'(1);
                st_next = sw_reg ? ST_SW_IN : ST_LF_TEST;
            end
            ST_SW_START: begin
                sw_next  = 1'b1;
                cnt_next = CNT_W'(cnt_leaf_reg);
                lv_next  = '0;
                if (cnt_leaf_reg == '0) begin
                    h_next  = '0;
                    st_next = ST_ROOT;
                end else begin
                    st_next = ST_SW_FIND;
                end
            end
            ST_SW_FIND: begin
                if (lv_reg < LV_W'(LEVELS - 1) && !cnt_reg[lv_reg]) begin
                    lv_next = lv_reg + LV_W'(1);
                end else begin
                    st_next = ST_SW_LOAD;
                end
            end
            ST_SW_LOAD: begin
                h_next  = ram_rd;
                mh_next = ml_valid_reg && ml_reg == lv_reg;
                st_next = ST_SW_OUT;
            end
            ST_SW_OUT: begin
                if (lv_reg < LV_W'(LEVELS) && cnt_reg != (CNT_W'(1) << lv_reg)) begin
                    st_next = mutable_reg ? ST_SW_SELF : ST_SW_ADV;
                end else begin
                    st_next = ST_ROOT;
                end
            end
            ST_SW_SELF: begin
                if (!(br_en_reg && mh_reg) || out_free) begin
                    emit      = br_en_reg && mh_reg;
                    emit_hash = h_reg;
                    hl_next   = h_reg;
                    ph_next   = PH_FIRST;
                    ret_next  = ST_SW_ADV;
                    st_next   = ST_H_GO;
                end
            end
            ST_SW_ADV: begin
                cnt_next = cnt_reg + (CNT_W'(1) << lv_reg);
                lv_next  = lv_reg + LV_W'(1);
                st_next  = ST_SW_IN;
            end
            ST_SW_IN: begin
                if (lv_reg < LV_W'(LEVELS) && !cnt_reg[lv_reg]) begin
                    st_next = ST_LF_RD;
                end else begin
                    st_next = ST_SW_OUT;
                end
            end
            ST_ROOT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_kind     = 1'b1;
                    emit_mut      = mut_reg;
                    emit_hash     = h_reg;
                    cnt_leaf_next = '0;
                    ml_valid_next = 1'b0;
                    mut_next      = 1'b0;
                    mh_next       = 1'b0;
                    st_next       = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - HASH_W - 1){1'b0}}, out_mut_reg, out_hash_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_root_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("root flag and last flag disagree");

    a_branch_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> !m_tdata[HASH_W])
        else $error("branch entry carries mutated flag");

    a_idle_core : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !core_busy)
        else $error("input taken while hash unit busy");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ rtl/mrk_ram.sv @@
`default_nettype none
module mrk_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ rtl/mrk_sha_core.sv @@
`default_nettype none
module mrk_sha_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire mrk_pkg::state_t  iv,
    input  wire mrk_pkg::block_t  blk,
    output logic                  busy,
    output logic                  done,
    output mrk_pkg::state_t       digest
);
    import mrk_pkg::*;

    state_t      v_reg, v_next;
    state_t      iv_reg;
    block_t      win_reg, win_next;
    logic [5:0]  rnd_reg;
    logic        run_reg, fin_reg, done_reg;
    state_t      dig_reg;

    logic [31:0] s1, ch, t1, s0, maj, t2, ws0, ws1;

    always_comb begin
        s1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + K_TAB[rnd_reg] + win_reg[0];
        s0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + maj;
        v_next    = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
        ws0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        ws1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        win_next = {win_reg[0] + ws0 + win_reg[9] + ws1, win_reg[15:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start && !run_reg) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end else if (run_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !run_reg) begin
            v_reg   <= iv;
            iv_reg  <= iv;
            win_reg <= blk;
        end else if (run_reg) begin
            v_reg   <= v_next;
            win_reg <= win_next;
        end
        if (fin_reg) begin
            for (int i = 0; i < 8; i++) begin
                dig_reg[i] <= iv_reg[i] + v_reg[i];
            end
        end
    end

    assign busy   = run_reg || fin_reg;
    assign done   = done_reg;
    assign digest = dig_reg;

endmodule
`default_nettype wire

@@ tb/sv/merkle_checker.sv @@
`default_nettype none
module merkle_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [mrk_pkg::IN_TDATA_W-1:0]     s_tdata,  // leaf_w0, leaf_w1, leaf_w2, leaf_w3
    input  wire logic                               s_tuser,  // has_leaf
    input  wire logic                               s_tlast,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [mrk_pkg::OUT_TDATA_W-1:0]    m_tdata,  // hash_w0..hash_w3, mutated, pad
    input  wire logic                               m_tuser,  // kind
    input  wire logic                               m_tlast,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mrk_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [mrk_pkg::CFG_W-1:0]          cfg_wdata,
    output int                                      errors,
    output int                                      outstanding
);
    import mrk_pkg::*;

    typedef struct {
        logic         kind;
        logic [255:0] hash;
        logic         mutated;
        logic         last;
    } merkle_result_t;

    localparam logic [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] MID_H [8] = '{
        32'h1e4e0f95, 32'h5a4bc81c, 32'h08c8af1c, 32'h94f34b9d,
        32'h0af2f450, 32'hdc24a3bc, 32'hef98318f, 32'haf5e2506};

    logic         cfg_mutable;
    logic         cfg_fast;
    logic         cfg_branch_en;
    logic [31:0]  cfg_branch_pos;
    logic [255:0] subtree [LEVELS];
    logic [31:0]  leaf_count;
    int           match_level;
    logic         mutated_seen;
    merkle_result_t pending_hashes [$];

    assign outstanding = pending_hashes.size();

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic state_t sha_round16(input state_t st, input block_t blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) st[i] = st[i] + v[i];
        return st;
    endfunction

    // hash byte 4j+b sits in bits 8(4j+b) up and is byte b of big-endian word j
    function automatic logic [31:0] be_word(input logic [255:0] h, input int j);
        return {h[32*j +: 8], h[32*j+8 +: 8], h[32*j+16 +: 8], h[32*j+24 +: 8]};
    endfunction

    function automatic logic [255:0] digest_of(input state_t st);
        logic [255:0] h;
        for (int j = 0; j < 8; j++)
            h[32*j +: 32] = {st[j][7:0], st[j][15:8], st[j][23:16], st[j][31:24]};
        return h;
    endfunction

    function automatic logic [255:0] node_hash(input logic [255:0] l, input logic [255:0] r,
                                               input logic fast);
        block_t blk;
        state_t st;
        for (int j = 0; j < 8; j++) begin
            blk[j]     = be_word(l, j);
            blk[j + 8] = be_word(r, j);
        end
        if (fast) begin
            for (int j = 0; j < 8; j++) st[j] = MID_H[j];
            return digest_of(sha_round16(st, blk));
        end
        for (int j = 0; j < 8; j++) st[j] = INIT_H[j];
        st = sha_round16(st, blk);
        blk = '0;
        blk[0] = 32'h80000000;
        blk[15] = 32'h00000200;
        st = sha_round16(st, blk);
        blk = '0;
        for (int j = 0; j < 8; j++) blk[j] = st[j];
        blk[8] = 32'h80000000;
        blk[15] = 32'h00000100;
        for (int j = 0; j < 8; j++) st[j] = INIT_H[j];
        return digest_of(sha_round16(st, blk));
    endfunction

    task automatic push_hash(input logic kind, input logic [255:0] h, input logic mut,
                             input logic last);
        merkle_result_t r;
        r.kind = kind; r.hash = h; r.mutated = mut; r.last = last;
        pending_hashes = {pending_hashes, r};
    endtask

    task automatic absorb_leaf(input logic [255:0] leaf);
        logic [255:0] h;
        logic [63:0]  cnt;
        int           lv;
        logic         mh;
        h = leaf;
        lv = 0;
        if (leaf_count == 32'hFFFFFFFF) return;
        mh = (leaf_count == cfg_branch_pos);
        leaf_count = leaf_count + 1;
        cnt = 64'(leaf_count);
        while (lv < LEVELS - 1 && !cnt[lv]) begin
            if (cfg_branch_en) begin
                if (mh) push_hash(1'b0, subtree[lv], 1'b0, 1'b0);
                else if (match_level == lv) begin
                    push_hash(1'b0, h, 1'b0, 1'b0);
                    mh = 1'b1;
                end
            end
            if (subtree[lv] == h) mutated_seen = 1'b1;
            h = node_hash(subtree[lv], h, cfg_fast);
            lv++;
        end
        subtree[lv] = h;
        if (mh) match_level = lv;
    endtask

    task automatic sweep_root();
        logic [255:0] h;
        logic [63:0]  cnt;
        int           lv;
        logic         mh;
        cnt = 64'(leaf_count);
        lv = 0;
        if (cnt == 0) begin
            push_hash(1'b1, '0, 1'b0, 1'b1);
            return;
        end
        while (lv < LEVELS - 1 && !cnt[lv]) lv++;
        h = subtree[lv];
        mh = (match_level == lv);
        while (lv < LEVELS && cnt != (64'd1 << lv)) begin
            if (cfg_mutable) begin
                if (cfg_branch_en && mh) push_hash(1'b0, h, 1'b0, 1'b0);
                h = node_hash(h, h, cfg_fast);
            end
            cnt = cnt + (64'd1 << lv);
            lv++;
            while (lv < LEVELS && !cnt[lv]) begin
                if (cfg_branch_en) begin
                    if (mh) push_hash(1'b0, subtree[lv], 1'b0, 1'b0);
                    else if (match_level == lv) begin
                        push_hash(1'b0, h, 1'b0, 1'b0);
                        mh = 1'b1;
                    end
                end
                h = node_hash(subtree[lv], h, cfg_fast);
                lv++;
            end
        end
        push_hash(1'b1, h, mutated_seen, 1'b1);
    endtask

    task automatic compare_result();
        merkle_result_t e;
        logic [255:0]   got;
        got = m_tdata[255:0];
        if (pending_hashes.size() == 0) begin
            $error("unexpected result transaction: kind %0d hash %h", m_tuser, got);
            errors++;
            return;
        end
        e = pending_hashes.pop_front();
        if (m_tuser !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, m_tuser);
            errors++;
        end
        for (int k = 0; k < 4; k++) begin
            if (got[64*k +: 64] !== e.hash[64*k +: 64]) begin
                $error("hash_w%0d: expected %h actual %h", k, e.hash[64*k +: 64],
                       got[64*k +: 64]);
                errors++;
            end
        end
        if (m_tdata[256] !== e.mutated) begin
            $error("mutated: expected %0d actual %0d", e.mutated, m_tdata[256]);
            errors++;
        end
        if (m_tlast !== e.last) begin
            $error("last_result: expected %0d actual %0d", e.last, m_tlast);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mutable = 1'b1;
            cfg_fast = 1'b0;
            cfg_branch_en = 1'b0;
            cfg_branch_pos = 32'hFFFFFFFF;
            leaf_count = '0;
            match_level = -1;
            mutated_seen = 1'b0;
            errors = 0;
            pending_hashes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_MUTABLE:    cfg_mutable = cfg_wdata[0];
                    REG_FAST:       cfg_fast = cfg_wdata[0];
                    REG_BRANCH_EN:  cfg_branch_en = cfg_wdata[0];
                    REG_BRANCH_POS: cfg_branch_pos = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) absorb_leaf(s_tdata);
                if (s_tlast) begin
                    sweep_root();
                    leaf_count = '0;
                    match_level = -1;
                    mutated_seen = 1'b0;
                end
            end
            if (m_tvalid && m_tready) compare_result();
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
    import mrk_pkg::*;

    localparam int QUIET_LIMIT = 60000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // leaf_w0, leaf_w1, leaf_w2, leaf_w3
    logic                   s_tuser;   // has_leaf
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // hash_w0..hash_w3, mutated, pad
    logic                   m_tuser;   // kind
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;
    int                     errors;
    int                     outstanding;
    int                     items_sent;
    int                     send_gap;
    int                     recv_stall;
    int                     quiet_cycles;
    logic [255:0]           prev_leaf;

    streaming_merkle_root_and_branch_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    merkle_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [255:0] random_leaf();
        logic [255:0] v;
        for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic [255:0] leaf, input logic has_leaf,
                             input logic eol);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= leaf;
        s_tuser <= has_leaf;
        s_tlast <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (items_sent == 123) begin
            send_gap = 72;
            recv_stall = 32;
        end else if (items_sent == 246) begin
            send_gap = 0;
            recv_stall = 0;
        end
    endtask

    // hold off until the block has drained, then write every register
    task automatic configure(input logic mut, input logic fast, input logic br_en,
                             input logic [31:0] pos);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MUTABLE;
        cfg_wdata <= 32'(mut);
        @(negedge aclk);
        cfg_index <= REG_FAST;
        cfg_wdata <= 32'(fast);
        @(negedge aclk);
        cfg_index <= REG_BRANCH_EN;
        cfg_wdata <= 32'(br_en);
        @(negedge aclk);
        cfg_index <= REG_BRANCH_POS;
        cfg_wdata <= pos;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_run(input int n_leaves, input logic last_has_leaf);
        logic [255:0] leaf;
        for (int i = 0; i < n_leaves; i++) begin
            if (i > 0 && $urandom_range(9) == 0) leaf = prev_leaf;
            else leaf = random_leaf();
            if ($urandom_range(7) == 0) send_item(random_leaf(), 1'b0, 1'b0);
            if (i == n_leaves - 1 && last_has_leaf) send_item(leaf, 1'b1, 1'b1);
            else send_item(leaf, 1'b1, 1'b0);
            prev_leaf = leaf;
        end
        if (!(n_leaves > 0 && last_has_leaf)) send_item(random_leaf(), 1'b0, 1'b1);
    endtask

    initial begin
        int          n;
        logic [31:0] pos;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MUTABLE;
        cfg_wdata = '0;
        items_sent = 0;
        send_gap = 32;
        recv_stall = 72;
        prev_leaf = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        configure(1'b1, 1'b0, 1'b1, 32'd0);
        send_item('0, 1'b1, 1'b0);
        send_item('0, 1'b1, 1'b0);
        send_item('1, 1'b0, 1'b0);
        send_item('1, 1'b1, 1'b0);
        send_item('1, 1'b1, 1'b1);
        configure(1'b0, 1'b1, 1'b1, 32'd2);
        send_run(3, 1'b0);
        configure(1'b1, 1'b1, 1'b1, 32'hFFFFFFFF);
        send_item('1, 1'b0, 1'b1);
        configure(1'b0, 1'b0, 1'b0, 32'd4);
        send_run(5, 1'b1);
        configure(1'b1, 1'b0, 1'b1, 32'd6);
        send_run(7, 1'b0);

        while (items_sent < 370) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
            case ($urandom_range(5))
                0: pos = 32'd0;
                1: pos = 32'hFFFFFFFF;
                2: pos = $urandom;
                default: pos = $urandom_range(n);
            endcase
            configure($urandom_range(1), $urandom_range(1), $urandom_range(3) != 0, pos);
            send_run(n, $urandom_range(1));
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/mrk_pkg.sv
rtl/mrk_ram.sv
rtl/mrk_sha_core.sv
rtl/streaming_merkle_root_and_branch_top.sv
tb/sv/merkle_checker.sv
tb/sv/tb.sv
